/* src/jfmc_pkg.sv */
// ----------------------------------------------------------------------------
// jfmc_pkg
// Shared types and constants for the joystick-to-motor command block.
// ----------------------------------------------------------------------------
`default_nettype none

package jfmc_pkg;

  typedef logic signed [11:0] speed_t;

  typedef struct packed {
    speed_t right_speed;
    speed_t left_speed;
  } speed_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ADDR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_OP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_OP = 2'd3;

  localparam logic [7:0] RIGHT_ADDR_RST  = 8'd1;
  localparam logic [7:0] LEFT_ADDR_RST   = 8'd2;
  localparam logic [7:0] ENABLE_OP_RST   = 8'd21;
  localparam logic [7:0] VELOCITY_OP_RST = 8'd63;

  localparam logic [7:0]  HEADER_OK  = 8'hFF;
  localparam logic [7:0]  BTN_STOP   = 8'h20;
  localparam logic [15:0] STICK_MID  = 16'h0200;
  localparam logic [15:0] BAND_LO    = 16'h0020;
  localparam logic [15:0] BAND_A_HI  = 16'h00C0;
  localparam logic [15:0] BAND_B_LO  = 16'h00C1;
  localparam logic [15:0] BAND_B_HI  = 16'h0160;
  localparam logic [15:0] BAND_C_LO  = 16'h0161;
  localparam logic [15:0] BAND_C_HI  = 16'h01FF;
  localparam logic [15:0] BAND_D_LO  = 16'h0201;
  localparam logic [15:0] BAND_HI    = 16'h0380;

  localparam speed_t SPD_FAST_FWD = 12'sd2000;
  localparam speed_t SPD_FWD      = 12'sd1000;
  localparam speed_t SPD_SLOW_FWD = 12'sd500;
  localparam speed_t SPD_ZERO     = 12'sd0;
  localparam speed_t SPD_SLOW_REV = -12'sd500;
  localparam speed_t SPD_REV      = -12'sd1000;

endpackage

`default_nettype wire

/* src/jfmc_front.sv */
// ----------------------------------------------------------------------------
// jfmc_front
// Checks and decodes one joystick frame and updates the held wheel speeds.
// ----------------------------------------------------------------------------
`default_nettype none

module jfmc_front
  import jfmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  header_byte,
  input  wire logic [15:0] stick_y,
  input  wire logic [15:0] stick_x,
  input  wire logic [15:0] stick_z,
  input  wire logic [7:0]  button_byte,
  input  wire logic [7:0]  checksum_byte,
  output speed_pair_t      speeds_nxt
);

  speed_t      left_speed_r;
  speed_t      right_speed_r;
  logic [7:0]  sum8;
  logic        frame_ok;
  logic [15:0] y_d;
  logic [15:0] x_d;
  logic [7:0]  btn_d;
  speed_t      x_speed;

  assign sum8 = stick_y[15:8] + stick_y[7:0] + stick_x[15:8] + stick_x[7:0]
              + stick_z[15:8] + stick_z[7:0] + button_byte;
  assign frame_ok = (header_byte == HEADER_OK) && (sum8 == checksum_byte);
  assign y_d   = frame_ok ? stick_y : 16'd0;
  assign x_d   = frame_ok ? stick_x : 16'd0;
  assign btn_d = frame_ok ? button_byte : 8'd0;

  always_comb begin
    priority if (x_d >= BAND_LO && x_d < BAND_A_HI) begin
      x_speed = SPD_FAST_FWD;
    end else if (x_d >= BAND_B_LO && x_d < BAND_B_HI) begin
      x_speed = SPD_FWD;
    end else if (x_d >= BAND_C_LO && x_d < BAND_C_HI) begin
      x_speed = SPD_SLOW_FWD;
    end else if (x_d == STICK_MID) begin
      x_speed = SPD_ZERO;
    end else if (x_d >= BAND_D_LO && x_d < BAND_HI) begin
      x_speed = SPD_SLOW_REV;
    end else begin
      x_speed = SPD_REV;
    end
  end

  always_comb begin
    speeds_nxt.left_speed  = left_speed_r;
    speeds_nxt.right_speed = right_speed_r;
    priority if (btn_d == BTN_STOP) begin
      speeds_nxt.left_speed  = SPD_ZERO;
      speeds_nxt.right_speed = SPD_ZERO;
    end else if (y_d == STICK_MID) begin
      speeds_nxt.left_speed  = x_speed;
      speeds_nxt.right_speed = x_speed;
    end else if (y_d >= BAND_LO && y_d < BAND_C_HI) begin
      speeds_nxt.left_speed  = SPD_REV;
      speeds_nxt.right_speed = SPD_FWD;
    end else if (y_d >= BAND_D_LO && y_d < BAND_HI) begin
      speeds_nxt.left_speed  = SPD_FWD;
      speeds_nxt.right_speed = SPD_REV;
    end else begin
      speeds_nxt.left_speed  = left_speed_r;
      speeds_nxt.right_speed = right_speed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_speed_r  <= SPD_ZERO;
      right_speed_r <= SPD_ZERO;
    end else if (take) begin
      left_speed_r  <= speeds_nxt.left_speed;
      right_speed_r <= speeds_nxt.right_speed;
    end
  end

endmodule

`default_nettype wire

/* src/jfmc_queue.sv */
// ----------------------------------------------------------------------------
// jfmc_queue
// Small FIFO of decoded speed pairs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module jfmc_queue
  import jfmc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire speed_pair_t push_data,
  input  wire logic        pop,
  output speed_pair_t      pop_data,
  output queue_stat_t      stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  speed_pair_t   mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/jfmc_back.sv */
// ----------------------------------------------------------------------------
// jfmc_back
// Holds the drive settings and emits four motor frames per speed pair.
// ----------------------------------------------------------------------------
`default_nettype none

module jfmc_back
  import jfmc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire speed_pair_t          head,
  input  wire logic                 head_empty,
  output logic                      head_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_address_out,
  output logic [7:0]                out_command_out,
  output logic [7:0]                out_value_byte_high,
  output logic [7:0]                out_value_byte_upper,
  output logic [7:0]                out_value_byte_lower,
  output logic [7:0]                out_value_byte_low,
  output logic [7:0]                out_check_even,
  output logic [7:0]                out_check_odd,
  output logic                      out_last_frame
);

  localparam logic [1:0] PH_EN_RIGHT  = 2'd0;
  localparam logic [1:0] PH_VEL_RIGHT = 2'd1;
  localparam logic [1:0] PH_EN_LEFT   = 2'd2;
  localparam logic [1:0] PH_VEL_LEFT  = 2'd3;

  logic [7:0]         right_addr_r;
  logic [7:0]         left_addr_r;
  logic [7:0]         enable_op_r;
  logic [7:0]         velocity_op_r;
  logic [1:0]         phase_r;
  logic               out_valid_r;
  logic [63:0]        word_r;
  logic               last_r;
  logic               load;
  logic signed [15:0] right_ext;
  logic signed [15:0] left_ext;
  logic signed [15:0] right_x10;
  logic signed [15:0] left_x10_neg;
  logic [7:0]         addr_sel;
  logic [7:0]         op_sel;
  logic [31:0]        value_sel;

  assign load     = !head_empty && (!out_valid_r || !out_stall);
  assign head_pop = load && (phase_r == PH_VEL_LEFT);

  assign right_ext    = {{4{head.right_speed[11]}}, head.right_speed};
  assign left_ext     = {{4{head.left_speed[11]}}, head.left_speed};
  assign right_x10    = (right_ext <<< 3) + (right_ext <<< 1);
  assign left_x10_neg = 16'sd0 - ((left_ext <<< 3) + (left_ext <<< 1));

  always_comb begin
    unique case (phase_r)
      PH_EN_RIGHT: begin
        addr_sel  = right_addr_r;
        op_sel    = enable_op_r;
        value_sel = '0;
      end
      PH_VEL_RIGHT: begin
        addr_sel  = right_addr_r;
        op_sel    = velocity_op_r;
        value_sel = {{16{right_x10[15]}}, right_x10};
      end
      PH_EN_LEFT: begin
        addr_sel  = left_addr_r;
        op_sel    = enable_op_r;
        value_sel = '0;
      end
      default: begin
        addr_sel  = left_addr_r;
        op_sel    = velocity_op_r;
        value_sel = {{16{left_x10_neg[15]}}, left_x10_neg};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_addr_r  <= RIGHT_ADDR_RST;
      left_addr_r   <= LEFT_ADDR_RST;
      enable_op_r   <= ENABLE_OP_RST;
      velocity_op_r <= VELOCITY_OP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RIGHT_ADDR:  right_addr_r  <= cfg_data;
        CFG_LEFT_ADDR:   left_addr_r   <= cfg_data;
        CFG_ENABLE_OP:   enable_op_r   <= cfg_data;
        default:         velocity_op_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_EN_RIGHT;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        phase_r     <= phase_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= {addr_sel, op_sel, value_sel,
                 addr_sel ^ value_sel[31:24] ^ value_sel[15:8],
                 op_sel ^ value_sel[23:16] ^ value_sel[7:0]};
      last_r <= (phase_r == PH_VEL_LEFT);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_address_out      = word_r[63:56];
  assign out_command_out      = word_r[55:48];
  assign out_value_byte_high  = word_r[47:40];
  assign out_value_byte_upper = word_r[39:32];
  assign out_value_byte_lower = word_r[31:24];
  assign out_value_byte_low   = word_r[23:16];
  assign out_check_even       = word_r[15:8];
  assign out_check_odd        = word_r[7:0];
  assign out_last_frame       = last_r;

endmodule

`default_nettype wire

/* src/joystick_frame_to_motor_commands.sv */
// ----------------------------------------------------------------------------
// joystick_frame_to_motor_commands
// Turns one remote-control joystick frame into four motor drive frames.
//
// Input channel (in_valid / in_stall): one word is a whole joystick frame.
// A frame with a bad header or checksum decodes as all zeros, so the held
// wheel speeds stay. Output channel (out_valid / out_stall): one word is
// one 8-byte motor frame; each input yields enable right, velocity right,
// enable left, velocity left, the last with out_last_frame set.
// A taken joystick frame is first written into the queue; the output
// register then loads its first motor frame, and the rest follow on
// consecutive unstalled cycles. The single output register sends one
// motor frame per cycle while out_stall is low. A queue of QUEUE_DEPTH
// decoded speed pairs sits between decoder and frame sequencer; in_stall
// rises only when it is full. While out_stall is high the output word
// holds. Reset clears the speeds to zero, empties the queue and loads the
// default addresses and opcodes. The cfg port never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_frame_to_motor_commands
  import jfmc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_header_byte,
  input  wire logic [15:0]          in_stick_y,
  input  wire logic [15:0]          in_stick_x,
  input  wire logic [15:0]          in_stick_z,
  input  wire logic [7:0]           in_button_byte,
  input  wire logic [7:0]           in_checksum_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_address_out,
  output logic [7:0]                out_command_out,
  output logic [7:0]                out_value_byte_high,
  output logic [7:0]                out_value_byte_upper,
  output logic [7:0]                out_value_byte_lower,
  output logic [7:0]                out_value_byte_low,
  output logic [7:0]                out_check_even,
  output logic [7:0]                out_check_odd,
  output logic                      out_last_frame,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  logic        take;
  speed_pair_t speeds_nxt;
  speed_pair_t head;
  queue_stat_t q_stat;
  logic        head_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign take      = in_valid && !q_stat.full;

  jfmc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .header_byte   (in_header_byte),
    .stick_y       (in_stick_y),
    .stick_x       (in_stick_x),
    .stick_z       (in_stick_z),
    .button_byte   (in_button_byte),
    .checksum_byte (in_checksum_byte),
    .speeds_nxt    (speeds_nxt)
  );

  jfmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (speeds_nxt),
    .pop       (head_pop),
    .pop_data  (head),
    .stat      (q_stat)
  );

  jfmc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .head                 (head),
    .head_empty           (q_stat.empty),
    .head_pop             (head_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_address_out      (out_address_out),
    .out_command_out      (out_command_out),
    .out_value_byte_high  (out_value_byte_high),
    .out_value_byte_upper (out_value_byte_upper),
    .out_value_byte_lower (out_value_byte_lower),
    .out_value_byte_low   (out_value_byte_low),
    .out_check_even       (out_check_even),
    .out_check_odd        (out_check_odd),
    .out_last_frame       (out_last_frame)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for joystick_frame_to_motor_commands. A directed table
// covers the stick bands, their edges and gaps, the stop button and bad
// frames. Several randomized phases follow, each under different addresses
// and opcodes. Every accepted joystick frame runs through a wheel-speed
// predictor, and each motor word from the block is matched against it.
// ----------------------------------------------------------------------------

module tb
  import jfmc_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 72;

  typedef struct packed {
    logic [7:0]  header;
    logic [15:0] y;
    logic [15:0] x;
    logic [15:0] z;
    logic [7:0]  button;
    logic [7:0]  checksum;
  } joy_frame_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] v3;
    logic [7:0] v2;
    logic [7:0] v1;
    logic [7:0] v0;
    logic [7:0] chk_even;
    logic [7:0] chk_odd;
    logic       last;
  } motor_word_t;

  typedef struct {
    joy_frame_t frm;
    bit         typed;
    int         right_val;
    int         left_val;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_header_byte = '0;
  logic [15:0] in_stick_y = '0;
  logic [15:0] in_stick_x = '0;
  logic [15:0] in_stick_z = '0;
  logic [7:0]  in_button_byte = '0;
  logic [7:0]  in_checksum_byte = '0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_address_out;
  logic [7:0] out_command_out;
  logic [7:0] out_value_byte_high;
  logic [7:0] out_value_byte_upper;
  logic [7:0] out_value_byte_lower;
  logic [7:0] out_value_byte_low;
  logic [7:0] out_check_even;
  logic [7:0] out_check_odd;
  logic       out_last_frame;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  joystick_frame_to_motor_commands dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_header_byte       (in_header_byte),
    .in_stick_y           (in_stick_y),
    .in_stick_x           (in_stick_x),
    .in_stick_z           (in_stick_z),
    .in_button_byte       (in_button_byte),
    .in_checksum_byte     (in_checksum_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_address_out      (out_address_out),
    .out_command_out      (out_command_out),
    .out_value_byte_high  (out_value_byte_high),
    .out_value_byte_upper (out_value_byte_upper),
    .out_value_byte_lower (out_value_byte_lower),
    .out_value_byte_low   (out_value_byte_low),
    .out_check_even       (out_check_even),
    .out_check_odd        (out_check_odd),
    .out_last_frame       (out_last_frame),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  speed_t      left_spd = SPD_ZERO;
  speed_t      right_spd = SPD_ZERO;
  logic [7:0]  cfg_mirror [4];
  motor_word_t pending_words [$];
  dir_row_t    dir_tab [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  function automatic logic [7:0] payload_sum(input joy_frame_t f);
    logic [7:0] s;
    s = f.y[15:8] + f.y[7:0] + f.x[15:8] + f.x[7:0] + f.z[15:8] + f.z[7:0] + f.button;
    return s;
  endfunction

  function automatic void predict_speeds(input joy_frame_t f, output int rv, output int lv);
    logic [15:0] y;
    logic [15:0] x;
    logic [7:0]  btn;
    speed_t      s;
    y = f.y;
    x = f.x;
    btn = f.button;
    if (!(f.header == HEADER_OK && payload_sum(f) == f.checksum)) begin
      y = '0;
      x = '0;
      btn = '0;
    end
    if (y == STICK_MID) begin
      if (x >= BAND_LO && x < BAND_A_HI) s = SPD_FAST_FWD;
      else if (x >= BAND_B_LO && x < BAND_B_HI) s = SPD_FWD;
      else if (x >= BAND_C_LO && x < BAND_C_HI) s = SPD_SLOW_FWD;
      else if (x == STICK_MID) s = SPD_ZERO;
      else if (x >= BAND_D_LO && x < BAND_HI) s = SPD_SLOW_REV;
      else s = SPD_REV;
      left_spd = s;
      right_spd = s;
    end else if (y >= BAND_LO && y < BAND_C_HI) begin
      left_spd = SPD_REV;
      right_spd = SPD_FWD;
    end else if (y >= BAND_D_LO && y < BAND_HI) begin
      left_spd = SPD_FWD;
      right_spd = SPD_REV;
    end
    if (btn == BTN_STOP) begin
      left_spd = SPD_ZERO;
      right_spd = SPD_ZERO;
    end
    rv = 10 * int'(right_spd);
    lv = -10 * int'(left_spd);
  endfunction

  function automatic motor_word_t mk_word(input logic [7:0] addr, input logic [7:0] cmd,
                                          input logic [31:0] val, input logic last);
    motor_word_t w;
    w.addr = addr;
    w.cmd = cmd;
    {w.v3, w.v2, w.v1, w.v0} = val;
    w.chk_even = addr ^ w.v3 ^ w.v1;
    w.chk_odd = cmd ^ w.v2 ^ w.v0;
    w.last = last;
    return w;
  endfunction

  function automatic void queue_words(input int rv, input int lv);
    logic [7:0] ra;
    logic [7:0] la;
    logic [7:0] en;
    logic [7:0] vel;
    ra = cfg_mirror[CFG_RIGHT_ADDR];
    la = cfg_mirror[CFG_LEFT_ADDR];
    en = cfg_mirror[CFG_ENABLE_OP];
    vel = cfg_mirror[CFG_VELOCITY_OP];
    pending_words.push_back(mk_word(ra, en, 32'd0, 1'b0));
    pending_words.push_back(mk_word(ra, vel, rv, 1'b0));
    pending_words.push_back(mk_word(la, en, 32'd0, 1'b0));
    pending_words.push_back(mk_word(la, vel, lv, 1'b1));
  endfunction

  function automatic dir_row_t mk_row(input logic [7:0] hdr, input logic [15:0] y,
                                      input logic [15:0] x, input logic [15:0] z,
                                      input logic [7:0] btn, input bit bad_sum,
                                      input bit typed, input int rv, input int lv);
    dir_row_t r;
    r.frm.header = hdr;
    r.frm.y = y;
    r.frm.x = x;
    r.frm.z = z;
    r.frm.button = btn;
    r.frm.checksum = payload_sum(r.frm) ^ (bad_sum ? 8'h01 : 8'h00);
    r.typed = typed;
    r.right_val = rv;
    r.left_val = lv;
    return r;
  endfunction

  function automatic logic [15:0] pick_stick();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        case ($urandom_range(0, 15))
          0: v = BAND_LO - 16'd1;
          1: v = BAND_LO;
          2: v = BAND_A_HI - 16'd1;
          3: v = BAND_A_HI;
          4: v = BAND_B_LO;
          5: v = BAND_B_HI - 16'd1;
          6: v = BAND_B_HI;
          7: v = BAND_C_LO;
          8: v = BAND_C_HI - 16'd1;
          9: v = BAND_C_HI;
          10: v = STICK_MID;
          11: v = BAND_D_LO;
          12: v = BAND_HI - 16'd1;
          13: v = BAND_HI;
          14: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      4, 5, 6: v = 16'($urandom_range(0, 16'h03FF));
      default: v = 16'($urandom_range(0, 16'hFFFF));
    endcase
    return v;
  endfunction

  function automatic joy_frame_t gen_frame();
    joy_frame_t f;
    int k;
    k = $urandom_range(0, 99);
    f.y = ($urandom_range(0, 99) < 45) ? STICK_MID : pick_stick();
    f.x = pick_stick();
    f.z = 16'($urandom_range(0, 16'hFFFF));
    f.button = ($urandom_range(0, 9) == 0) ? BTN_STOP : 8'($urandom_range(0, 255));
    f.header = HEADER_OK;
    f.checksum = payload_sum(f);
    if (k >= 95) begin
      f.header = 8'($urandom_range(0, 255));
      f.checksum = 8'($urandom_range(0, 255));
    end else if (k >= 90) begin
      f.checksum = f.checksum + 8'd1;
    end else if (k >= 85) begin
      f.header = 8'($urandom_range(0, 254));
    end
    return f;
  endfunction

  task automatic cmp8(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %02h, got %02h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic send_frame(input joy_frame_t f, input bit typed, input int tr, input int tl);
    int rv;
    int lv;
    in_valid <= 1'b1;
    in_header_byte <= f.header;
    in_stick_y <= f.y;
    in_stick_x <= f.x;
    in_stick_z <= f.z;
    in_button_byte <= f.button;
    in_checksum_byte <= f.checksum;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_speeds(f, rv, lv);
    if (typed) begin
      rv = tr;
      lv = tl;
    end
    queue_words(rv, lv);
  endtask

  task automatic pace(input int max_gap);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_mirror[idx] = d;
  endtask

  task automatic load_cfg(input logic [7:0] ra, input logic [7:0] la,
                          input logic [7:0] en, input logic [7:0] vel);
    cfg_write(CFG_RIGHT_ADDR, ra);
    cfg_write(CFG_LEFT_ADDR, la);
    cfg_write(CFG_ENABLE_OP, en);
    cfg_write(CFG_VELOCITY_OP, vel);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // result side: stall pattern changes mode every so often
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycle_count[2];
      endcase
    end
  end

  always @(posedge clk) begin
    motor_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("motor word with none expected: addr %02h cmd %02h",
               out_address_out, out_command_out);
        mismatches++;
      end else begin
        w = pending_words.pop_front();
        cmp8("address_out", w.addr, out_address_out);
        cmp8("command_out", w.cmd, out_command_out);
        cmp8("value_byte_high", w.v3, out_value_byte_high);
        cmp8("value_byte_upper", w.v2, out_value_byte_upper);
        cmp8("value_byte_lower", w.v1, out_value_byte_lower);
        cmp8("value_byte_low", w.v0, out_value_byte_low);
        cmp8("check_even", w.chk_even, out_check_even);
        cmp8("check_odd", w.chk_odd, out_check_odd);
        cmp8("last_frame", {7'd0, w.last}, {7'd0, out_last_frame});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cfg_mirror[CFG_RIGHT_ADDR] = RIGHT_ADDR_RST;
    cfg_mirror[CFG_LEFT_ADDR] = LEFT_ADDR_RST;
    cfg_mirror[CFG_ENABLE_OP] = ENABLE_OP_RST;
    cfg_mirror[CFG_VELOCITY_OP] = VELOCITY_OP_RST;

    // header, y, x, z, button, bad sum, typed, right value, left value
    dir_tab.push_back(mk_row(8'h00, STICK_MID, BAND_LO, 16'h0000, 8'h00, 0, 1, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_LO, 16'h0000, 8'h00, 0, 1,
                             20000, -20000));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_A_HI - 16'd1, 16'h1234, 8'h00,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_A_HI, 16'h0000, 8'h00, 0, 1,
                             -10000, 10000));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_B_LO, 16'h0000, 8'h00, 0, 1,
                             10000, -10000));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_B_HI - 16'd1, 16'h8000, 8'h01,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_B_HI, 16'h0000, 8'h00, 0, 1,
                             -10000, 10000));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_C_LO, 16'h0000, 8'h00, 0, 1,
                             5000, -5000));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_C_HI - 16'd1, 16'h00FF, 8'h80,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_C_HI, 16'h0000, 8'h00, 0, 1,
                             -10000, 10000));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, STICK_MID, 16'h0000, 8'h00, 0, 1, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_D_LO, 16'h0000, 8'h00, 0, 1,
                             -5000, 5000));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_HI - 16'd1, 16'h5A5A, 8'h40,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_HI, 16'h0000, 8'h00, 0, 1,
                             -10000, 10000));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, BAND_LO - 16'd1, 16'h0000, 8'h00, 0, 1,
                             -10000, 10000));
    dir_tab.push_back(mk_row(HEADER_OK, STICK_MID, 16'hFFFF, 16'hFFFF, 8'hDF, 0, 1,
                             -10000, 10000));
    dir_tab.push_back(mk_row(HEADER_OK, BAND_LO, 16'h0000, 16'h0000, 8'h00, 0, 1,
                             10000, 10000));
    dir_tab.push_back(mk_row(HEADER_OK, BAND_C_HI - 16'd1, 16'h0200, 16'h0F0F, 8'h10,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, BAND_D_LO, 16'h0000, 16'h0000, 8'h00, 0, 1,
                             -10000, -10000));
    dir_tab.push_back(mk_row(HEADER_OK, BAND_HI - 16'd1, 16'h0100, 16'hF0F0, 8'h08,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, 16'hFFFF, 16'h0040, 16'h0000, 8'hFF, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, 16'h0000, 16'hFFFF, 16'hA5A5, 8'h00, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, BAND_D_LO, BAND_LO, 16'h0000, BTN_STOP, 0, 1, 0, 0));
    dir_tab.push_back(mk_row(HEADER_OK, BAND_LO, BAND_LO, 16'h0000, 8'h00, 1, 1, 0, 0));
    dir_tab.push_back(mk_row(8'hFE, BAND_D_LO, BAND_LO, 16'h0000, BTN_STOP, 0, 1, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      pace(6);
      send_frame(dir_tab[i].frm, dir_tab[i].typed, dir_tab[i].right_val, dir_tab[i].left_val);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph)
        0: load_cfg(8'h00, 8'h00, 8'h00, 8'h00);
        1: load_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        2: load_cfg(8'hFF, 8'h00, 8'h80, 8'h7F);
        default: load_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pace((ph == 2) ? 0 : 8);
        send_frame(gen_frame(), 1'b0, 0, 0);
      end
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
